// File: design/srzc_pkg.sv
// Shared constants and register indexes for the sliding RMS and zero-crossing meter.
package srzc_pkg;

    localparam int unsigned DEF_MAX_WINDOW = 4096;

    localparam int unsigned WIN_CFG_W  = 13;
    localparam int unsigned RATE_CFG_W = 18;
    localparam int unsigned FREQ_CFG_W = 25;
    localparam int unsigned CFG_DATA_W = 25;
    localparam int unsigned CODE_W     = 7;
    localparam int unsigned TOTAL_W    = 13;
    localparam int unsigned LEVEL_W    = 8;

    // Register indexes on the configuration port.
    localparam logic [1:0] CFG_WINDOW   = 2'd0;
    localparam logic [1:0] CFG_RATE     = 2'd1;
    localparam logic [1:0] CFG_MIN_FREQ = 2'd2;
    localparam logic [1:0] CFG_MAX_FREQ = 2'd3;

    localparam logic [WIN_CFG_W-1:0]  WINDOW_RST   = 13'd4096;
    localparam logic [RATE_CFG_W-1:0] RATE_RST     = 18'd48000;
    localparam logic [FREQ_CFG_W-1:0] MIN_FREQ_RST = 25'd256;
    localparam logic [FREQ_CFG_W-1:0] MAX_FREQ_RST = 25'd2560;

    // Controller values are centered by this offset.
    localparam logic signed [LEVEL_W-1:0] LEVEL_OFFSET = 8'sd63;

    // RMS code c is valid while (c*RMS_STEP)^2 * W <= RMS_FULL * square_sum.
    localparam logic [12:0] RMS_STEP = 13'd5656;
    localparam logic [27:0] RMS_FULL = 28'd252015625;
    localparam int unsigned RMS_SQ_W = 40;

    localparam logic [CODE_W-1:0] CODE_MAX = 7'd127;

    localparam logic FUNC_TICK  = 1'b0;
    localparam logic FUNC_EVENT = 1'b1;

endpackage

// File: design/srzc_ram.sv
// Single-port-write, single-port-read synchronous memory holding levels and crossing marks.
module srzc_ram
    import srzc_pkg::*;
#(
    parameter int unsigned DEPTH  = DEF_MAX_WINDOW,
    parameter int unsigned DATA_W = LEVEL_W + 1
)
(
    input  logic                     clk,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [DATA_W-1:0]        rd_data,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DATA_W-1:0]        wr_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: design/srzc_rms.sv
// Bit-by-bit search for the RMS code; each bit passes through a square, a scale and a compare phase.
module srzc_rms
    import srzc_pkg::*;
#(
    parameter int unsigned MAX_WINDOW = DEF_MAX_WINDOW
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic [$clog2(MAX_WINDOW*4096+1)-1:0] square_sum,
    input  logic [$clog2(MAX_WINDOW+1)-1:0]      window,
    output logic                                 busy,
    output logic [CODE_W-1:0]                    code
);

    localparam int unsigned SW = $clog2(MAX_WINDOW*4096+1);
    localparam int unsigned WW = $clog2(MAX_WINDOW+1);
    localparam int unsigned RW = SW + 28;
    localparam int unsigned PW = RMS_SQ_W + WW;
    localparam int unsigned CW = (RW > PW) ? RW : PW;

    typedef enum logic [2:0] {
        PH_SQUARE = 3'b001,
        PH_SCALE  = 3'b010,
        PH_TEST   = 3'b100
    } phase_t;

    phase_t                phase_reg;
    logic                  busy_reg;
    logic [2:0]            bit_reg;
    logic [CODE_W-1:0]     code_reg;
    logic [RW-1:0]         rhs_reg;
    logic [WW-1:0]         win_reg;
    logic [RMS_SQ_W-1:0]   sq_reg;
    logic [PW-1:0]         prod_reg;
    logic [CODE_W-1:0]     trial;
    logic [19:0]           step_val;

    assign trial    = code_reg | (CODE_W'(1) << bit_reg);
    assign step_val = 20'(trial) * 20'(RMS_STEP);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SQUARE;
            busy_reg  <= 1'b0;
            bit_reg   <= 3'd6;
            code_reg  <= '0;
        end
        else if (start)
        begin
            phase_reg <= PH_SQUARE;
            busy_reg  <= 1'b1;
            bit_reg   <= 3'd6;
            code_reg  <= '0;
        end
        else if (busy_reg)
        begin
            unique case (phase_reg)
                PH_SQUARE: phase_reg <= PH_SCALE;
                PH_SCALE:  phase_reg <= PH_TEST;
                PH_TEST:
                begin
                    phase_reg <= PH_SQUARE;
                    if (CW'(prod_reg) <= CW'(rhs_reg))
                    begin
                        code_reg <= trial;
                    end
                    if (bit_reg == 3'd0)
                    begin
                        busy_reg <= 1'b0;
                    end
                    else
                    begin
                        bit_reg <= bit_reg - 3'd1;
                    end
                end
                default: phase_reg <= PH_SQUARE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rhs_reg <= RW'(square_sum) * RW'(RMS_FULL);
            win_reg <= window;
        end
        sq_reg   <= RMS_SQ_W'(step_val) * RMS_SQ_W'(step_val);
        prod_reg <= PW'(sq_reg) * PW'(win_reg);
    end

    assign busy = busy_reg;
    assign code = code_reg;

endmodule

// File: design/srzc_freq.sv
// Crossing frequency code: product setup, range clamp and a seven-step restoring divide.
module srzc_freq
    import srzc_pkg::*;
#(
    parameter int unsigned MAX_WINDOW = DEF_MAX_WINDOW
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [$clog2(MAX_WINDOW+1)-1:0] crossings,
    input  logic [$clog2(MAX_WINDOW+1)-1:0] window,
    input  logic [RATE_CFG_W-1:0]           sample_rate,
    input  logic [FREQ_CFG_W-1:0]           min_frequency,
    input  logic [FREQ_CFG_W-1:0]           max_frequency,
    output logic                            busy,
    output logic [CODE_W-1:0]               code
);

    localparam int unsigned WW = $clog2(MAX_WINDOW+1);
    localparam int unsigned NW = WW + RATE_CFG_W;
    localparam int unsigned LW = FREQ_CFG_W + WW;
    localparam int unsigned BW = ((NW + 7) > LW) ? (NW + 7) : LW;
    localparam int unsigned DW = BW + 7;

    typedef enum logic [2:0] {
        PH_MUL  = 3'b001,
        PH_PREP = 3'b010,
        PH_DIV  = 3'b100
    } phase_t;

    phase_t            phase_reg;
    logic              busy_reg;
    logic [2:0]        bit_reg;
    logic [CODE_W-1:0] code_reg;
    logic [NW-1:0]     n_reg;
    logic [LW-1:0]     lo_reg;
    logic [LW-1:0]     hi_reg;
    logic [DW-1:0]     num_reg;
    logic [DW-1:0]     den_reg;
    logic [BW-1:0]     n_scaled;
    logic [BW-1:0]     span;
    logic [DW-1:0]     den_shift;

    assign n_scaled  = BW'(n_reg) << 7;
    assign span      = n_scaled - BW'(lo_reg);
    assign den_shift = den_reg << bit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_MUL;
            busy_reg  <= 1'b0;
            bit_reg   <= 3'd6;
            code_reg  <= '0;
        end
        else if (start)
        begin
            phase_reg <= PH_MUL;
            busy_reg  <= 1'b1;
            bit_reg   <= 3'd6;
            code_reg  <= '0;
        end
        else if (busy_reg)
        begin
            unique case (phase_reg)
                PH_MUL: phase_reg <= PH_PREP;
                PH_PREP:
                begin
                    // Empty range and out-of-range frequencies finish here.
                    if (max_frequency <= min_frequency || n_scaled <= BW'(lo_reg))
                    begin
                        code_reg <= '0;
                        busy_reg <= 1'b0;
                    end
                    else if (n_scaled >= BW'(hi_reg))
                    begin
                        code_reg <= CODE_MAX;
                        busy_reg <= 1'b0;
                    end
                    else
                    begin
                        phase_reg <= PH_DIV;
                    end
                end
                PH_DIV:
                begin
                    if (num_reg >= den_shift)
                    begin
                        code_reg[bit_reg] <= 1'b1;
                    end
                    if (bit_reg == 3'd0)
                    begin
                        busy_reg <= 1'b0;
                    end
                    else
                    begin
                        bit_reg <= bit_reg - 3'd1;
                    end
                end
                default: phase_reg <= PH_MUL;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (phase_reg == PH_MUL)
        begin
            n_reg  <= NW'(crossings) * NW'(sample_rate);
            lo_reg <= LW'(min_frequency) * LW'(window);
            hi_reg <= LW'(max_frequency) * LW'(window);
        end
        if (phase_reg == PH_PREP)
        begin
            // Numerator times 127 as a shift and subtract.
            num_reg <= (DW'(span) << 7) - DW'(span);
            den_reg <= DW'(BW'(hi_reg) - BW'(lo_reg));
        end
        else if (phase_reg == PH_DIV && num_reg >= den_shift)
        begin
            num_reg <= num_reg - den_shift;
        end
    end

    assign busy = busy_reg;
    assign code = code_reg;

endmodule

// File: design/sliding_rms_zero_crossing_meter.sv
// Top level of the sliding-window RMS and zero-crossing meter.
// Every request is either a sample tick (func = 0) or a controller value change (func = 1),
// and every request produces exactly one result carrying the RMS code, the crossing
// frequency code and the number of live crossings in the window. Levels and crossing marks
// live together in one synchronous memory of MAX_WINDOW entries; each request goes through
// a read-modify-write sequence on that memory (one entry for an event, two for a tick), and
// then the RMS search and the frequency divider run side by side. The RMS search is the
// slower of the two and sets the pace; a new request is accepted only after the previous
// result has moved into the output register. A finished result sits in that register, so
// the next request may be accepted while it waits. After reset the block sweeps the memory
// to zero, one entry per cycle, over all MAX_WINDOW entries; in_ready stays low during that
// sweep while configuration writes are taken as usual. Configuration should be written only
// while no request is in flight.
module sliding_rms_zero_crossing_meter
    import srzc_pkg::*;
#(
    parameter int unsigned MAX_WINDOW = DEF_MAX_WINDOW
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  func,
    input  logic [6:0]            cc_value,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [CODE_W-1:0]     rms_code,
    output logic [CODE_W-1:0]     frequency_code,
    output logic [TOTAL_W-1:0]    crossing_total,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int unsigned PW = $clog2(MAX_WINDOW);
    localparam int unsigned WW = $clog2(MAX_WINDOW+1);
    localparam int unsigned SW = $clog2(MAX_WINDOW*4096+1);
    localparam int unsigned XW = (WW > WIN_CFG_W) ? WW : WIN_CFG_W;
    localparam int unsigned MW = LEVEL_W + 1;

    typedef enum logic [7:0] {
        S_CLEAR = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_RD_A  = 8'b0000_0100,
        S_WR_A  = 8'b0000_1000,
        S_RD_B  = 8'b0001_0000,
        S_WR_B  = 8'b0010_0000,
        S_CALC  = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers.
    logic [WIN_CFG_W-1:0]  window_reg;
    logic [RATE_CFG_W-1:0] rate_reg;
    logic [FREQ_CFG_W-1:0] min_freq_reg;
    logic [FREQ_CFG_W-1:0] max_freq_reg;

    // Meter state.
    logic [PW-1:0]             pos_reg;
    logic [SW-1:0]             sum_reg;
    logic [WW-1:0]             live_reg;
    logic signed [LEVEL_W-1:0] held_reg;
    logic [PW-1:0]             clr_reg;

    // Accepted request.
    logic       func_reg;
    logic [6:0] cc_reg;

    // Output register.
    logic                  out_valid_reg;
    logic [CODE_W-1:0]     rms_out_reg;
    logic [CODE_W-1:0]     freq_out_reg;
    logic [TOTAL_W-1:0]    total_out_reg;

    logic [WW-1:0]             win_eff;
    logic [WW-1:0]             pos_inc;
    logic [PW-1:0]             pos_after;
    logic signed [LEVEL_W-1:0] level_new;
    logic                      crossing;
    logic                      mem_rd_en;
    logic [PW-1:0]             mem_rd_addr;
    logic [MW-1:0]             mem_rd_data;
    logic                      mem_we;
    logic [PW-1:0]             mem_waddr;
    logic [MW-1:0]             mem_wdata;
    logic signed [LEVEL_W-1:0] old_level;
    logic signed [15:0]        old_sq;
    logic signed [15:0]        new_sq;
    logic                      calc_start;
    logic                      rms_busy;
    logic                      freq_busy;
    logic [CODE_W-1:0]         rms_val;
    logic [CODE_W-1:0]         freq_val;

    // A window of zero behaves as one; a window beyond the memory is clipped to it.
    always_comb
    begin
        if (window_reg == '0)
        begin
            win_eff = WW'(1);
        end
        else if (XW'(window_reg) > XW'(MAX_WINDOW))
        begin
            win_eff = WW'(MAX_WINDOW);
        end
        else
        begin
            win_eff = WW'(window_reg);
        end
    end

    assign pos_inc   = WW'(pos_reg) + WW'(1);
    assign pos_after = (pos_inc >= win_eff) ? '0 : PW'(pos_inc);

    assign level_new = LEVEL_W'(signed'({1'b0, cc_reg})) - LEVEL_OFFSET;
    assign crossing  = (held_reg >= 0 && level_new < 0) || (held_reg <= 0 && level_new > 0);

    assign old_level = signed'(mem_rd_data[LEVEL_W-1:0]);
    assign old_sq    = 16'(old_level) * 16'(old_level);
    assign new_sq    = 16'(held_reg) * 16'(held_reg);

    // Memory access per state.
    always_comb
    begin
        mem_rd_en   = 1'b0;
        mem_rd_addr = pos_reg;
        mem_we      = 1'b0;
        mem_waddr   = pos_reg;
        mem_wdata   = mem_rd_data;
        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = '0;
            end
            S_RD_A:
            begin
                mem_rd_en = 1'b1;
            end
            S_WR_A:
            begin
                if (func_reg == FUNC_EVENT)
                begin
                    mem_we    = crossing && !mem_rd_data[LEVEL_W];
                    mem_wdata = {1'b1, mem_rd_data[LEVEL_W-1:0]};
                end
                else
                begin
                    mem_we    = 1'b1;
                    mem_wdata = {mem_rd_data[LEVEL_W], held_reg};
                end
            end
            S_RD_B:
            begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = pos_reg;
            end
            S_WR_B:
            begin
                mem_we    = mem_rd_data[LEVEL_W];
                mem_wdata = {1'b0, mem_rd_data[LEVEL_W-1:0]};
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR: if (clr_reg == PW'(MAX_WINDOW - 1)) state_next = S_IDLE;
            S_IDLE:  if (in_valid) state_next = S_RD_A;
            S_RD_A:  state_next = S_WR_A;
            S_WR_A:  state_next = (func_reg == FUNC_EVENT) ? S_CALC : S_RD_B;
            S_RD_B:  state_next = S_WR_B;
            S_WR_B:  state_next = S_CALC;
            S_CALC:  if (!rms_busy && !freq_busy) state_next = S_DONE;
            S_DONE:  if (!out_valid_reg || out_ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // Both arithmetic units start on entry to the calculation state.
    assign calc_start = (state_reg == S_WR_B) ||
                        (state_reg == S_WR_A && func_reg == FUNC_EVENT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            pos_reg       <= '0;
            sum_reg       <= '0;
            live_reg      <= '0;
            held_reg      <= '0;
            out_valid_reg <= 1'b0;
            window_reg    <= WINDOW_RST;
            rate_reg      <= RATE_RST;
            min_freq_reg  <= MIN_FREQ_RST;
            max_freq_reg  <= MAX_FREQ_RST;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_WINDOW:   window_reg   <= cfg_data[WIN_CFG_W-1:0];
                    CFG_RATE:     rate_reg     <= cfg_data[RATE_CFG_W-1:0];
                    CFG_MIN_FREQ: min_freq_reg <= cfg_data[FREQ_CFG_W-1:0];
                    CFG_MAX_FREQ: max_freq_reg <= cfg_data[FREQ_CFG_W-1:0];
                    default:      window_reg   <= window_reg;
                endcase
            end

            if (state_reg == S_CLEAR)
            begin
                clr_reg <= clr_reg + PW'(1);
            end

            if (state_reg == S_WR_A)
            begin
                if (func_reg == FUNC_EVENT)
                begin
                    held_reg <= level_new;
                    if (crossing && !mem_rd_data[LEVEL_W])
                    begin
                        live_reg <= live_reg + WW'(1);
                    end
                end
                else
                begin
                    sum_reg <= sum_reg - SW'(unsigned'(old_sq)) + SW'(unsigned'(new_sq));
                    pos_reg <= pos_after;
                end
            end

            // A mark expires when the write position returns to its slot.
            if (state_reg == S_WR_B && mem_rd_data[LEVEL_W])
            begin
                live_reg <= live_reg - WW'(1);
            end

            if (state_reg == S_DONE && (!out_valid_reg || out_ready))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
        begin
            func_reg <= func;
            cc_reg   <= cc_value;
        end
        if (state_reg == S_DONE && (!out_valid_reg || out_ready))
        begin
            rms_out_reg   <= rms_val;
            freq_out_reg  <= freq_val;
            total_out_reg <= TOTAL_W'(live_reg);
        end
    end

    srzc_ram #(
        .DEPTH  (MAX_WINDOW),
        .DATA_W (MW)
    ) u_ram (
        .clk     (clk),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata)
    );

    srzc_rms #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_rms (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (calc_start),
        .square_sum (sum_reg),
        .window     (win_eff),
        .busy       (rms_busy),
        .code       (rms_val)
    );

    srzc_freq #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_freq (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (calc_start),
        .crossings     (live_reg),
        .window        (win_eff),
        .sample_rate   (rate_reg),
        .min_frequency (min_freq_reg),
        .max_frequency (max_freq_reg),
        .busy          (freq_busy),
        .code          (freq_val)
    );

    assign in_ready       = (state_reg == S_IDLE);
    assign out_valid      = out_valid_reg;
    assign rms_code       = rms_out_reg;
    assign frequency_code = freq_out_reg;
    assign crossing_total = total_out_reg;

`ifndef SYNTH
    // The memory is never written while the block waits for a request.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !mem_we)
        else $error("memory written while idle");

    // The live crossing count never exceeds the number of slots.
    assert property (@(posedge clk) disable iff (!rst_n)
        WW'(live_reg) <= WW'(MAX_WINDOW))
        else $error("live crossing count overflow");

    // An accepted request starts its memory read in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == S_RD_A))
        else $error("accepted request did not start");

    // Both units are busy right after they are started.
    assert property (@(posedge clk) disable iff (!rst_n)
        calc_start |=> (rms_busy && freq_busy))
        else $error("arithmetic units did not start");
`endif

endmodule

// File: test/sliding_rms_zero_crossing_meter_tb.sv
// Self-checking testbench for the sliding RMS and zero-crossing meter.
module sliding_rms_zero_crossing_meter_tb
    import srzc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned RING = DEF_MAX_WINDOW;
    // The watchdog allows for the memory sweep after reset, the long receiver
    // hold-off and generous per-request latency.
    localparam int unsigned IDLE_LIMIT = 40000;

    typedef struct packed {
        logic [CODE_W-1:0]  rms;
        logic [CODE_W-1:0]  freq;
        logic [TOTAL_W-1:0] total;
    } meter_reading_t;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    logic                  func;
    logic [6:0]            cc_value;
    logic                  out_valid;
    logic                  out_ready;
    logic [CODE_W-1:0]     rms_code;
    logic [CODE_W-1:0]     frequency_code;
    logic [TOTAL_W-1:0]    crossing_total;
    logic                  cfg_we;
    logic [1:0]            cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    sliding_rms_zero_crossing_meter dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .func(func), .cc_value(cc_value),
        .out_valid(out_valid), .out_ready(out_ready),
        .rms_code(rms_code), .frequency_code(frequency_code),
        .crossing_total(crossing_total),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // Shadow copy of the meter state and its registers.
    logic signed [LEVEL_W-1:0] level_ring [RING];
    bit                        mark_ring  [RING];
    int unsigned               slot;
    longint unsigned           energy;
    int unsigned               live_marks;
    int                        held;
    int unsigned               win_reg;
    int unsigned               rate_reg;
    int unsigned               fmin_reg;
    int unsigned               fmax_reg;

    meter_reading_t pending_readings[$];
    int  mismatches;
    bit  timed_out;
    int  quiet_cycles;
    bit  sink_hold;      // The long hold-off of the receiver.
    bit  sink_calm;      // A stretch in which neither side idles.

    always #5 clk = ~clk;

    function automatic longint unsigned eff_window();
        longint unsigned w;
        w = win_reg;
        if (w == 0) w = 1;
        if (w > RING) w = RING;
        return w;
    endfunction

    // Advance the shadow state by one request and queue the reading it yields.
    task automatic predict_request(input logic f, input logic [6:0] v);
        longint unsigned w;
        longint unsigned rhs;
        longint unsigned t;
        longint unsigned n;
        longint unsigned lo;
        longint unsigned hi;
        int                old_lvl;
        int                new_lvl;
        int unsigned       c;
        meter_reading_t    r;
        w = eff_window();
        if (f == FUNC_EVENT) begin
            old_lvl = held;
            new_lvl = int'(v) - 63;
            held = new_lvl;
            if ((old_lvl >= 0 && new_lvl < 0) || (old_lvl <= 0 && new_lvl > 0)) begin
                if (!mark_ring[slot]) begin
                    mark_ring[slot] = 1'b1;
                    live_marks++;
                end
            end
        end else begin
            old_lvl = level_ring[slot];
            energy = energy - longint'(old_lvl * old_lvl) + longint'(held * held);
            level_ring[slot] = LEVEL_W'(held);
            slot = (slot + 1 >= w) ? 0 : slot + 1;
            if (mark_ring[slot]) begin
                mark_ring[slot] = 1'b0;
                live_marks--;
            end
        end
        rhs = 64'd15875 * 64'd15875 * energy;
        c = 0;
        while (c < 127) begin
            t = (c + 1) * 5656;
            if (t * t * w > rhs) break;
            c++;
        end
        r.rms = c[CODE_W-1:0];
        if (fmax_reg <= fmin_reg) begin
            r.freq = '0;
        end else begin
            n  = longint'(live_marks) * rate_reg * 128;
            lo = longint'(fmin_reg) * w;
            hi = longint'(fmax_reg) * w;
            if (n <= lo)      r.freq = '0;
            else if (n >= hi) r.freq = CODE_MAX;
            else              r.freq = CODE_W'(((n - lo) * 127) / (hi - lo));
        end
        r.total = live_marks[TOTAL_W-1:0];
        pending_readings.push_back(r);
    endtask

    // Offer one request, with a random gap before it unless sink_calm is set, and predict it on acceptance.
    // Valid stays high after acceptance until the next request or an idle cycle.
    task automatic send_request(input logic f, input logic [6:0] v);
        while (!sink_calm && $urandom_range(99) < 21) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        func     <= f;
        cc_value <= v;
        do @(posedge clk); while (!in_ready);
        predict_request(f, v);
    endtask

    task automatic send_event(input int unsigned v);
        send_request(FUNC_EVENT, v[6:0]);
    endtask

    task automatic send_tick();
        send_request(FUNC_TICK, 7'($urandom));
    endtask

    // Wait until every reading is in and any request still in flight has settled.
    task automatic drain();
        in_valid <= 1'b0;
        while (pending_readings.size() != 0) @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input int unsigned value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[CFG_DATA_W-1:0];
        @(posedge clk);
        case (idx)
            CFG_WINDOW:   win_reg  = value & 32'h1FFF;
            CFG_RATE:     rate_reg = value & 32'h3FFFF;
            CFG_MIN_FREQ: fmin_reg = value & 32'h1FFFFFF;
            default:      fmax_reg = value & 32'h1FFFFFF;
        endcase
    endtask

    task automatic set_config(input int unsigned w, input int unsigned r,
                              input int unsigned lo, input int unsigned hi);
        drain();
        write_reg(CFG_WINDOW, w);
        write_reg(CFG_RATE, r);
        write_reg(CFG_MIN_FREQ, lo);
        write_reg(CFG_MAX_FREQ, hi);
        cfg_we <= 1'b0;
    endtask

    // Extreme levels, the zero level, and crossings in both directions.
    task automatic test_level_extremes();
        send_event(127);
        send_tick();
        send_event(0);
        send_event(0);
        send_tick();
        send_event(63);
        send_tick();
        send_event(64);
        send_event(62);
        send_tick();
        send_tick();
    endtask

    // Repeated crossings at one slot, then marks that expire as the ring wraps.
    task automatic test_crossing_wrap();
        set_config(4, 48000, 0, 24576000);
        send_event(127);
        send_event(0);
        send_event(127);
        send_event(63);
        for (int i = 0; i < 6; i++) send_tick();
    endtask

    // Odd registers: window zero and over range, reversed range, widest clamps.
    task automatic test_register_extremes();
        set_config(0, 1000, 24576000, 1);
        send_event(0);
        send_event(127);
        send_tick();
        set_config(8191, 192000, 0, 24576000);
        send_event(0);
        send_tick();
        set_config(1, 262143, 33554431, 33554431);
        send_event(100);
        send_tick();
    endtask

    // Shrinking the window below the write position forces a wrap to slot zero.
    task automatic test_window_shrink();
        set_config(64, 48000, 256, 2560);
        for (int i = 0; i < 20; i++) send_tick();
        set_config(3, 48000, 256, 2560);
        send_event(10);
        send_tick();
        send_tick();
    endtask

    // Random traffic: events that swing through zero mixed with somewhat more ticks, in several settings.
    task automatic test_random_traffic(input int unsigned count);
        int unsigned v;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(99) < 45) begin
                case ($urandom_range(3))
                    0: v = $urandom_range(127);
                    1: v = $urandom_range(62, 64);
                    2: v = (held >= 0) ? $urandom_range(62) : $urandom_range(127, 64);
                    default: v = $urandom_range(1) ? 0 : 127;
                endcase
                send_event(v);
            end else begin
                send_tick();
            end
        end
    endtask

    // Receiver holds off for a long stretch so the block backs up on its input.
    task automatic test_backpressure();
        fork
            begin
                sink_hold = 1'b1;
                repeat (400) @(posedge clk);
                sink_hold = 1'b0;
            end
            for (int i = 0; i < 8; i++) send_tick();
        join
    endtask

    // Receiver side: random stalls except during the calm stretch or the hold-off.
    always @(posedge clk) begin
        if (!rst_n) out_ready <= 1'b0;
        else if (sink_hold) out_ready <= 1'b0;
        else out_ready <= sink_calm || ($urandom_range(99) >= 21);
    end

    // Compare each accepted reading with the oldest prediction.
    always @(posedge clk) begin
        meter_reading_t exp_r;
        if (rst_n && out_valid && out_ready) begin
            if (pending_readings.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected reading rms=%0d freq=%0d total=%0d",
                                               rms_code, frequency_code, crossing_total);
            end else begin
                exp_r = pending_readings[0];
                pending_readings.delete(0);
                if (rms_code !== exp_r.rms || frequency_code !== exp_r.freq
                        || crossing_total !== exp_r.total) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected rms=%0d freq=%0d total=%0d, got %0d %0d %0d",
                                 exp_r.rms, exp_r.freq, exp_r.total,
                                 rms_code, frequency_code, crossing_total);
                end
            end
        end
    end

    // Watchdog on cycles with no request or result moving.
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > IDLE_LIMIT) begin
            $display("sliding_rms_zero_crossing_meter verification failed");
            $finish;
        end
    end

    initial begin
        clk = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        func = FUNC_TICK;
        cc_value = '0;
        cfg_we = 1'b0;
        cfg_index = CFG_WINDOW;
        cfg_data = '0;
        mismatches = 0;
        quiet_cycles = 0;
        sink_hold = 1'b0;
        sink_calm = 1'b0;
        for (int i = 0; i < RING; i++) begin
            level_ring[i] = '0;
            mark_ring[i] = 1'b0;
        end
        slot = 0;
        energy = 0;
        live_marks = 0;
        held = 0;
        win_reg = WINDOW_RST;
        rate_reg = RATE_RST;
        fmin_reg = MIN_FREQ_RST;
        fmax_reg = MAX_FREQ_RST;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_level_extremes();
        test_crossing_wrap();
        test_register_extremes();
        test_window_shrink();
        set_config(16, 48000, 0, 1536000);
        test_random_traffic(250);
        test_backpressure();
        sink_calm = 1'b1;
        set_config(8, 192000, 256000, 24576000);
        test_random_traffic(150);
        sink_calm = 1'b0;
        set_config(5, 1000, 100, 600);
        test_random_traffic(250);
        set_config(4096, 48000, 256, 2560);
        test_random_traffic(300);
        drain();

        if (mismatches == 0 && pending_readings.size() == 0)
            $display("sliding_rms_zero_crossing_meter verification clean");
        else
            $display("sliding_rms_zero_crossing_meter verification failed");
        $finish;
    end

endmodule

// File: files.f
design/srzc_pkg.sv
design/srzc_ram.sv
design/srzc_rms.sv
design/srzc_freq.sv
design/sliding_rms_zero_crossing_meter.sv
test/sliding_rms_zero_crossing_meter_tb.sv
